/* hdl/bssi_pkg.sv */
`timescale 1ns / 1ps

package bssi_pkg;

    // Width of stamp counts; covers the whole MAX_STAMPS range plus one.
    localparam int CNT_W = 7;
    // Width of twice a remainder (below twice the stamp count).
    localparam int FRAC_W = CNT_W + 1;
    localparam int COORD_W = 16;
    localparam int COLOR_W = 32;
    localparam int LAYER_W = 13;
    localparam int RADIUS_W = 10;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_LAYER_WIDTH = 2'd0;
    localparam logic [1:0] REG_LAYER_HEIGHT = 2'd1;

    // One classified point, ready for stamp generation.
    typedef struct packed {
        logic [COORD_W-1:0] base_x;
        logic [COORD_W-1:0] base_y;
        logic               neg_x;
        logic               neg_y;
        logic [COORD_W-1:0] step_x;
        logic [COORD_W-1:0] step_y;
        logic [FRAC_W-1:0]  frac_x;
        logic [FRAC_W-1:0]  frac_y;
        logic [CNT_W-1:0]   count;
        logic [COLOR_W-1:0] color;
        logic               clipped;
        logic [14:0]        x0;
        logic [14:0]        y0;
        logic [15:0]        x1;
        logic [15:0]        y1;
    } bssi_job_t;

endpackage

/* hdl/bssi_div.sv */
`timescale 1ns / 1ps

module bssi_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [bssi_pkg::COORD_W-1:0] dividend,
    input  logic [bssi_pkg::CNT_W-1:0]   divisor,
    output logic                        busy,
    output logic [bssi_pkg::COORD_W-1:0] quotient,
    output logic [bssi_pkg::CNT_W-1:0]   remainder
);
    import bssi_pkg::*;

    localparam int STEP_W = $clog2(COORD_W + 1);

    logic [STEP_W-1:0]  steps_reg, steps_next;
    logic [COORD_W-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]   div_reg, div_next;
    logic [CNT_W:0]     trial;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        steps_next = steps_reg;
        quot_next = quot_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        trial = {rem_reg, quot_reg[COORD_W-1]};
        if (start) begin
            steps_next = STEP_W'(COORD_W);
            quot_next = dividend;
            rem_next = '0;
            div_next = divisor;
        end else if (steps_reg != '0) begin
            steps_next = steps_reg - 1'b1;
            if (trial >= {1'b0, div_reg}) begin
                rem_next = CNT_W'(trial - {1'b0, div_reg});
                quot_next = {quot_reg[COORD_W-2:0], 1'b1};
            end else begin
                rem_next = trial[CNT_W-1:0];
                quot_next = {quot_reg[COORD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steps_reg <= '0;
        end else begin
            steps_reg <= steps_next;
        end
        quot_reg <= quot_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy = (steps_reg != '0);
    assign quotient = quot_reg;
    assign remainder = rem_reg;

endmodule

/* hdl/bssi_front.sv */
`timescale 1ns / 1ps

module bssi_front #(
    parameter int MAX_STAMPS = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [15:0]                  point_x,
    input  logic [15:0]                  point_y,
    input  logic [bssi_pkg::RADIUS_W-1:0] brush_radius,
    input  logic [31:0]                  brush_color,
    input  logic                         stroke_start,
    input  logic [bssi_pkg::LAYER_W-1:0]  layer_width,
    input  logic [bssi_pkg::LAYER_W-1:0]  layer_height,
    output logic                         job_valid,
    input  logic                         job_ready,
    output bssi_pkg::bssi_job_t           job
);
    import bssi_pkg::*;

    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_STAMPS);
    localparam logic [CNT_W-1:0] MAX_P1 = CNT_W'(MAX_STAMPS + 1);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_SQ   = 3'd1;
    localparam logic [2:0] F_BIG  = 3'd2;
    localparam logic [2:0] F_MUL  = 3'd3;
    localparam logic [2:0] F_CMP  = 3'd4;
    localparam logic [2:0] F_DIV  = 3'd5;
    localparam logic [2:0] F_WAIT = 3'd6;
    localparam logic [2:0] F_PUSH = 3'd7;

    logic [2:0]  state_reg;
    logic        have_prev_reg;
    logic [15:0] prev_x_reg, prev_y_reg;

    logic        first_reg;
    logic [15:0] base_x_reg, base_y_reg;
    logic        neg_x_reg, neg_y_reg;
    logic [15:0] adx_reg, ady_reg;
    logic [15:0] unit_reg;
    logic [31:0] color_reg;
    logic [14:0] x0_reg, y0_reg;
    logic [15:0] x1_reg, y1_reg;
    logic [31:0] dx2_reg, dy2_reg;
    logic [46:0] big_reg;
    logic [22:0] span_reg;
    logic [45:0] sq_reg;
    logic [CNT_W-1:0] k_reg, n_reg;
    logic        clipped_reg;

    logic        accept;
    logic        first;
    logic [15:0] from_x, from_y;
    logic [16:0] dx17, dy17;
    logic [16:0] adx17, ady17;
    logic signed [17:0] lo_x, lo_y, hi_x, hi_y, lim_x, lim_y;
    logic signed [15:0] min_x, max_x, min_y, max_y;
    logic [10:0] pad;
    logic [CNT_W-1:0] n_found;
    logic        div_start, busy_x, busy_y;
    logic [15:0] quot_x, quot_y;
    logic [CNT_W-1:0] rem_x, rem_y;

    assign in_ready = (state_reg == F_IDLE);
    assign accept = in_valid && in_ready;
    assign first = stroke_start || !have_prev_reg;

    // Segment start, offsets and their magnitudes.
    always_comb begin
        from_x = first ? point_x : prev_x_reg;
        from_y = first ? point_y : prev_y_reg;
        dx17 = {point_x[15], point_x} - {from_x[15], from_x};
        dy17 = {point_y[15], point_y} - {from_y[15], from_y};
        adx17 = dx17[16] ? 17'(17'd0 - dx17) : dx17;
        ady17 = dy17[16] ? 17'(17'd0 - dy17) : dy17;
    end

    // Padded bounding box, clipped to the layer.
    always_comb begin
        pad = {1'b0, brush_radius} + 11'd2;
        min_x = ($signed(from_x) < $signed(point_x)) ? $signed(from_x) : $signed(point_x);
        max_x = ($signed(from_x) < $signed(point_x)) ? $signed(point_x) : $signed(from_x);
        min_y = ($signed(from_y) < $signed(point_y)) ? $signed(from_y) : $signed(point_y);
        max_y = ($signed(from_y) < $signed(point_y)) ? $signed(point_y) : $signed(from_y);
        lo_x = 18'(min_x) - $signed({7'd0, pad});
        lo_y = 18'(min_y) - $signed({7'd0, pad});
        hi_x = 18'(max_x) + $signed({7'd0, pad});
        hi_y = 18'(max_y) + $signed({7'd0, pad});
        lim_x = $signed({5'd0, layer_width}) - 18'sd1;
        lim_y = $signed({5'd0, layer_height}) - 18'sd1;
    end

    // Final stamp count once the search stops.
    always_comb begin
        n_found = n_reg;
        if (sq_reg <= big_reg[45:0] || big_reg[46]) begin
            n_found = k_reg;
        end
    end

    assign div_start = (state_reg == F_DIV);

    bssi_div u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (adx_reg),
        .divisor   (n_reg),
        .busy      (busy_x),
        .quotient  (quot_x),
        .remainder (rem_x)
    );

    bssi_div u_div_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (ady_reg),
        .divisor   (n_reg),
        .busy      (busy_y),
        .quotient  (quot_y),
        .remainder (rem_y)
    );

    // Sequencer: squares, scaled distance, count search, divisions, hand-off.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            have_prev_reg <= 1'b0;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (accept) begin
                        have_prev_reg <= 1'b1;
                        prev_x_reg <= point_x;
                        prev_y_reg <= point_y;
                        state_reg <= first ? F_PUSH : F_SQ;
                    end
                end
                F_SQ: begin
                    state_reg <= F_BIG;
                end
                F_BIG: begin
                    state_reg <= F_MUL;
                end
                F_MUL: begin
                    state_reg <= F_CMP;
                end
                F_CMP: begin
                    if ((sq_reg <= big_reg[45:0] || big_reg[46]) && k_reg != MAX_P1) begin
                        state_reg <= F_MUL;
                    end else begin
                        state_reg <= F_DIV;
                    end
                end
                F_DIV: begin
                    state_reg <= F_WAIT;
                end
                F_WAIT: begin
                    if (!busy_x && !busy_y) begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (job_ready) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    // Working registers of the current point.
    always_ff @(posedge aclk) begin
        case (state_reg)
            F_IDLE: begin
                first_reg <= first;
                base_x_reg <= from_x;
                base_y_reg <= from_y;
                neg_x_reg <= dx17[16];
                neg_y_reg <= dy17[16];
                adx_reg <= adx17[15:0];
                ady_reg <= ady17[15:0];
                unit_reg <= (brush_radius >= 10'd3) ? 16'(16'd35 * {6'd0, brush_radius})
                                                    : 16'd100;
                color_reg <= brush_color;
                x0_reg <= lo_x[17] ? 15'd0 : lo_x[14:0];
                y0_reg <= lo_y[17] ? 15'd0 : lo_y[14:0];
                x1_reg <= (hi_x < lim_x) ? hi_x[15:0] : lim_x[15:0];
                y1_reg <= (hi_y < lim_y) ? hi_y[15:0] : lim_y[15:0];
                n_reg <= CNT_W'(1);
                clipped_reg <= 1'b0;
            end
            F_SQ: begin
                dx2_reg <= adx_reg * adx_reg;
                dy2_reg <= ady_reg * ady_reg;
            end
            F_BIG: begin
                big_reg <= 47'(({1'b0, dx2_reg} + {1'b0, dy2_reg}) * 33'd10000);
                span_reg <= {7'd0, unit_reg};
                k_reg <= CNT_W'(1);
                n_reg <= '0;
            end
            F_MUL: begin
                sq_reg <= span_reg * span_reg;
            end
            F_CMP: begin
                if ((sq_reg <= big_reg[45:0] || big_reg[46]) && k_reg != MAX_P1) begin
                    n_reg <= k_reg;
                    k_reg <= k_reg + 1'b1;
                    span_reg <= span_reg + {7'd0, unit_reg};
                end else if (n_found > MAX_N) begin
                    n_reg <= MAX_N;
                    clipped_reg <= 1'b1;
                end else if (n_found == '0) begin
                    n_reg <= CNT_W'(1);
                end else begin
                    n_reg <= n_found;
                end
            end
            default: begin
            end
        endcase
    end

    // Job word: per-stamp whole step and doubled remainder of each axis.
    always_comb begin
        job.base_x = base_x_reg;
        job.base_y = base_y_reg;
        job.neg_x = neg_x_reg;
        job.neg_y = neg_y_reg;
        job.step_x = first_reg ? '0 : quot_x;
        job.step_y = first_reg ? '0 : quot_y;
        job.frac_x = first_reg ? '0 : {rem_x, 1'b0};
        job.frac_y = first_reg ? '0 : {rem_y, 1'b0};
        job.count = n_reg;
        job.color = color_reg;
        job.clipped = clipped_reg;
        job.x0 = x0_reg;
        job.y0 = y0_reg;
        job.x1 = x1_reg;
        job.y1 = y1_reg;
    end

    assign job_valid = (state_reg == F_PUSH);

endmodule

/* hdl/bssi_queue.sv */
`timescale 1ns / 1ps

module bssi_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  bssi_pkg::bssi_job_t push_job,
    output logic                pop_valid,
    input  logic                pop_ready,
    output bssi_pkg::bssi_job_t pop_job
);
    import bssi_pkg::*;

    bssi_job_t   slot_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  fill_reg;
    logic        do_push, do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid = (fill_reg != 2'd0);
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_valid && pop_ready;
    assign pop_job = slot_reg[rd_ptr_reg];

    // Two-entry ring of jobs between the front and the back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* hdl/bssi_back.sv */
`timescale 1ns / 1ps

module bssi_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    output logic                job_ready,
    input  bssi_pkg::bssi_job_t job,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [127:0]        out_data,
    output logic                out_last,
    output logic                out_clipped
);
    import bssi_pkg::*;

    logic              busy_reg;
    bssi_job_t         job_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [15:0]       acc_x_reg, acc_y_reg;
    logic [FRAC_W-1:0] rem_x_reg, rem_y_reg;
    logic              valid_reg;
    logic [127:0]      data_reg;
    logic              last_reg;
    logic              clipped_reg;

    logic              out_free, step;
    logic [FRAC_W-1:0] twice_n;
    logic [FRAC_W:0]   sum_x, sum_y;
    logic [FRAC_W-1:0] rem_x_next, rem_y_next;
    logic [15:0]       acc_x_next, acc_y_next;
    logic [15:0]       stamp_x, stamp_y;
    logic              is_last;

    assign out_free = !valid_reg || out_ready;
    assign job_ready = !busy_reg;
    assign step = busy_reg && out_free;

    // Next stamp: add whole step, carry one when the doubled remainder wraps.
    always_comb begin
        twice_n = {job_reg.count, 1'b0};
        sum_x = {1'b0, rem_x_reg} + {1'b0, job_reg.frac_x};
        sum_y = {1'b0, rem_y_reg} + {1'b0, job_reg.frac_y};
        acc_x_next = acc_x_reg + job_reg.step_x;
        acc_y_next = acc_y_reg + job_reg.step_y;
        rem_x_next = sum_x[FRAC_W-1:0];
        rem_y_next = sum_y[FRAC_W-1:0];
        if (sum_x >= {1'b0, twice_n}) begin
            rem_x_next = FRAC_W'(sum_x - {1'b0, twice_n});
            acc_x_next = acc_x_next + 16'd1;
        end
        if (sum_y >= {1'b0, twice_n}) begin
            rem_y_next = FRAC_W'(sum_y - {1'b0, twice_n});
            acc_y_next = acc_y_next + 16'd1;
        end
        stamp_x = job_reg.base_x + (job_reg.neg_x ? 16'(16'd0 - acc_x_next) : acc_x_next);
        stamp_y = job_reg.base_y + (job_reg.neg_y ? 16'(16'd0 - acc_y_next) : acc_y_next);
        is_last = (k_reg == job_reg.count);
    end

    // Stamp sequencer and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (out_ready) begin
                valid_reg <= 1'b0;
            end
            if (!busy_reg && job_valid) begin
                busy_reg <= 1'b1;
            end else if (step) begin
                valid_reg <= 1'b1;
                if (is_last) begin
                    busy_reg <= 1'b0;
                end
            end
        end
        if (!busy_reg && job_valid) begin
            job_reg <= job;
            k_reg <= CNT_W'(1);
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            rem_x_reg <= {1'b0, job.count};
            rem_y_reg <= {1'b0, job.count};
        end else if (step) begin
            k_reg <= k_reg + 1'b1;
            acc_x_reg <= acc_x_next;
            acc_y_reg <= acc_y_next;
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
            data_reg <= {2'b00,
                         is_last ? job_reg.y1 : 16'd0,
                         is_last ? job_reg.x1 : 16'd0,
                         is_last ? job_reg.y0 : 15'd0,
                         is_last ? job_reg.x0 : 15'd0,
                         job_reg.color, stamp_y, stamp_x};
            last_reg <= is_last;
            clipped_reg <= job_reg.clipped;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;
    assign out_last = last_reg;
    assign out_clipped = clipped_reg;

endmodule

/* hdl/brush_stroke_stamp_interpolator.sv */
`timescale 1ns / 1ps

// Brush stroke stamp interpolator. Each input word is one pointer point; the
// block answers with one stamp word at the first point of a stroke and with
// n evenly spaced stamps (1 to MAX_STAMPS) from the remembered point to the
// new one otherwise. The final word of a point carries tlast and the dirty
// rectangle; tuser is set on every word of a point whose count saturated.
// Flow: a first point goes straight to the job hand-off; any other point
// passes the stamp count search (one candidate per multiply and compare
// state pair) and the 16-step offset dividers in the front. The back emits
// one stamp per cycle unless m_tready stalls it, overlapping the front via
// a two-job queue. Configure the layer size only while the block is idle.
module brush_stroke_stamp_interpolator #(
    parameter int MAX_STAMPS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // point_x[15:0], point_y[31:16], brush_radius[41:32], brush_color[73:42]
    input  logic [79:0]  s_tdata,
    // stroke_start[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // stamp_x[15:0], stamp_y[31:16], stamp_color[63:32], dirty_x0[78:64],
    // dirty_y0[93:79], dirty_x1[109:94], dirty_y1[125:110]
    output logic [127:0] m_tdata,
    // last_stamp
    output logic         m_tlast,
    // steps_clipped[0]
    output logic         m_tuser,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_addr,
    input  logic [12:0]  cfg_wdata
);
    import bssi_pkg::*;

    logic [LAYER_W-1:0] layer_width_reg, layer_height_reg;
    logic               push_valid, push_ready, pop_valid, pop_ready;
    bssi_job_t          push_job, pop_job;

    // Layer size registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layer_width_reg <= 13'd1024;
            layer_height_reg <= 13'd1024;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_LAYER_WIDTH:  layer_width_reg <= cfg_wdata;
                REG_LAYER_HEIGHT: layer_height_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    bssi_front #(
        .MAX_STAMPS (MAX_STAMPS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .point_x      (s_tdata[15:0]),
        .point_y      (s_tdata[31:16]),
        .brush_radius (s_tdata[41:32]),
        .brush_color  (s_tdata[73:42]),
        .stroke_start (s_tuser),
        .layer_width  (layer_width_reg),
        .layer_height (layer_height_reg),
        .job_valid    (push_valid),
        .job_ready    (push_ready),
        .job          (push_job)
    );

    bssi_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    bssi_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (pop_valid),
        .job_ready   (pop_ready),
        .job         (pop_job),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (m_tdata),
        .out_last    (m_tlast),
        .out_clipped (m_tuser)
    );

endmodule
